// ===== hw/rtl/bounded_two_pass_ratio_test_unit_assert.svh =====
// Assertion macros for the bounded two-pass ratio test unit.
// Included by the top level; no other dependencies.
`ifndef BOUNDED_TWO_PASS_RATIO_TEST_UNIT_ASSERT_SVH
`define BOUNDED_TWO_PASS_RATIO_TEST_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BTPRT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BTPRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTPRT_ASSERT(lbl, clk, rstn, prop, msg)
`define BTPRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/btprt_pkg.sv =====
// Shared types and constants of the bounded two-pass ratio test unit.
// No dependencies.
package btprt_pkg;

	localparam int DW              = 32;
	localparam int FRAC            = 16;
	localparam int IDXW            = 16;
	localparam int TOLW            = 16;
	localparam int TOL_XW          = 20;
	localparam int INDEX_WIDTH_DEF = 16;
	localparam int NUMW            = DW + 1 + FRAC;
	localparam int DIV_STEPS       = NUMW;
	localparam int DIV_CW          = $clog2(DIV_STEPS);
	localparam int QDEPTH          = 2;
	localparam int QPW             = $clog2(QDEPTH);
	localparam int QCW             = $clog2(QDEPTH + 1);

	localparam logic signed [DW-1:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic [TOLW-1:0]      PTOL_RESET = 16'd1;

	localparam logic SIDE_LOWER = 1'b0;
	localparam logic SIDE_UPPER = 1'b1;

	typedef enum logic {
		OP_RELAXED = 1'b0,
		OP_FINAL   = 1'b1
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic                   first;
		logic                   last;
		logic                   upd;
		logic                   div_en;
		logic                   sat_max;
		logic                   den_neg;
		logic [DW-1:0]          mag;
		logic signed [DW:0]     diff;
		logic [IDXW-1:0]        idx;
	} fe_entry_t;

endpackage

// ===== hw/rtl/btprt_front.sv =====
// Front end: classifies one request, picks the bound and forms the ratio operands.
// Depends on btprt_pkg.
module btprt_front (
	input  logic                         operation,
	input  logic                         first,
	input  logic                         last,
	input  logic signed [31:0]           direction,
	input  logic signed [31:0]           lower_bound,
	input  logic signed [31:0]           upper_bound,
	input  logic signed [31:0]           old_value,
	input  logic signed [31:0]           new_value,
	input  logic [btprt_pkg::IDXW-1:0]   element_index,
	input  logic [btprt_pkg::TOLW-1:0]   ptol,
	output btprt_pkg::fe_entry_t         entry
);
	import btprt_pkg::*;

	logic [TOL_XW-1:0]  tol;
	logic [DW-1:0]      mag;
	logic               mag_gt_tol;
	logic signed [DW:0] diff_lo;
	logic signed [DW:0] diff_hi;
	logic               sel_lo;
	logic               sel_hi;
	logic               use_lo;
	logic               unbounded;

	assign tol = TOL_XW'({ptol, 3'b000}) + TOL_XW'({ptol, 1'b0});
	assign mag = direction[DW-1] ? (~direction + 1'b1) : direction;
	assign mag_gt_tol = mag > {{(DW-TOL_XW){1'b0}}, tol};
	assign diff_lo = {lower_bound[DW-1], lower_bound} - {old_value[DW-1], old_value};
	assign diff_hi = {upper_bound[DW-1], upper_bound} - {old_value[DW-1], old_value};

	assign sel_lo = direction[DW-1] && mag_gt_tol && (lower_bound > new_value);
	assign sel_hi = !sel_lo && !direction[DW-1] && mag_gt_tol && (upper_bound < new_value);
	assign unbounded = direction[DW-1] ? (lower_bound == S32_MIN) : (upper_bound == S32_MAX);

	always_comb begin
		entry.op      = op_t'(operation);
		entry.first   = first;
		entry.last    = last;
		entry.den_neg = direction[DW-1];
		entry.mag     = mag;
		entry.idx     = element_index;
		unique case (op_t'(operation))
			OP_RELAXED: begin
				use_lo        = sel_lo;
				entry.upd     = sel_lo || sel_hi;
				entry.div_en  = sel_lo || sel_hi;
				entry.sat_max = 1'b0;
			end
			OP_FINAL: begin
				use_lo        = direction[DW-1];
				entry.upd     = 1'b1;
				entry.div_en  = !unbounded;
				entry.sat_max = unbounded;
			end
			default: begin
				use_lo        = 1'b0;
				entry.upd     = 1'b0;
				entry.div_en  = 1'b0;
				entry.sat_max = 1'b0;
			end
		endcase
		entry.diff = use_lo ? diff_lo : diff_hi;
	end

endmodule

// ===== hw/rtl/btprt_queue.sv =====
// Short queue between front and back ends.
// Depends on btprt_pkg.
module btprt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  btprt_pkg::fe_entry_t wr_entry,
	output logic                 full,
	input  logic                 pop,
	output btprt_pkg::fe_entry_t rd_entry,
	output logic                 empty
);
	import btprt_pkg::*;

	fe_entry_t        mem_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == QCW'(QDEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			priority if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

// ===== hw/rtl/btprt_back.sv =====
// Back end: bit-serial ratio divider, saturation, running reduction and result register.
// Depends on btprt_pkg.
module btprt_back #(
	parameter int INDEX_WIDTH = btprt_pkg::INDEX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [btprt_pkg::TOLW-1:0]   ptol,
	input  btprt_pkg::fe_entry_t         q_entry,
	input  logic                         q_empty,
	output logic                         q_pop,
	output logic                         busy,
	input  logic                         pop,
	output logic                         empty,
	output logic                         pass_done,
	output logic signed [31:0]           step_length,
	output logic                         bound_met,
	output logic [btprt_pkg::IDXW-1:0]   entering_index,
	output logic                         entering_side,
	output logic                         no_pivot_error
);
	import btprt_pkg::*;

	localparam int KW = (INDEX_WIDTH < IDXW) ? INDEX_WIDTH : IDXW;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SAT  = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t              state_q;
	fe_entry_t           ent_q;
	logic [NUMW-1:0]     dvd_q;
	logic [DW-1:0]       rem_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic signed [DW-1:0] a_q;

	logic signed [DW-1:0] relaxed_q;
	logic [DW-1:0]        best_q;
	logic signed [DW-1:0] cstep_q;
	logic [KW-1:0]        cidx_q;
	logic                 cside_q;
	logic                 out_valid_q;

	logic [DW:0]          diff_abs;
	logic [DW:0]          rem_sh;
	logic [DW:0]          rem_sub;
	logic                 ge;
	logic                 qneg;
	logic                 neg_big;
	logic                 pos_big;
	logic [DW-1:0]        qlow_neg;
	logic signed [DW-1:0] a_sat;

	logic signed [DW-1:0] r_base;
	logic signed [DW-1:0] r_new;
	logic [DW-1:0]        b_base;
	logic signed [DW-1:0] c_base;
	logic [KW-1:0]        ci_base;
	logic                 cs_base;
	logic                 take;
	logic [DW-1:0]        b_new;
	logic signed [DW-1:0] c_new;
	logic [KW-1:0]        ci_new;
	logic                 cs_new;
	logic [IDXW-1:0]      ci_ext;
	logic                 upd_go;
	logic                 res_load;

	assign busy  = state_q != ST_IDLE;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign empty = !out_valid_q;

	assign diff_abs = q_entry.diff[DW] ? (~q_entry.diff + 1'b1) : q_entry.diff;

	assign rem_sh  = {rem_q, dvd_q[NUMW-1]};
	assign ge      = rem_sh >= {1'b0, ent_q.mag};
	assign rem_sub = rem_sh - {1'b0, ent_q.mag};

	assign qneg     = ent_q.diff[DW] ^ ent_q.den_neg;
	assign neg_big  = (|dvd_q[NUMW-1:DW]) || (dvd_q[DW-1] && (|dvd_q[DW-2:0]));
	assign pos_big  = |dvd_q[NUMW-1:DW-1];
	assign qlow_neg = ~dvd_q[DW-1:0] + 1'b1;

	always_comb begin
		priority if (ent_q.sat_max || !ent_q.div_en) begin
			a_sat = S32_MAX;
		end else if (qneg) begin
			a_sat = neg_big ? S32_MIN : $signed(qlow_neg);
		end else begin
			a_sat = pos_big ? S32_MAX : $signed(dvd_q[DW-1:0]);
		end
	end

	// running reductions with the first-element restart folded in
	always_comb begin
		r_base  = ent_q.first ? ONE_Q16 : relaxed_q;
		r_new   = (ent_q.upd && (a_q < r_base)) ? a_q : r_base;
		b_base  = ent_q.first ? '0 : best_q;
		c_base  = ent_q.first ? '0 : cstep_q;
		ci_base = ent_q.first ? '0 : cidx_q;
		cs_base = ent_q.first ? SIDE_LOWER : cside_q;
		take    = (ent_q.mag > b_base) && (a_q < relaxed_q);
		b_new   = take ? ent_q.mag : b_base;
		c_new   = take ? a_q : c_base;
		ci_new  = take ? ent_q.idx[KW-1:0] : ci_base;
		cs_new  = take ? (ent_q.den_neg ? SIDE_LOWER : SIDE_UPPER) : cs_base;
	end

	generate
		if (KW < IDXW) begin : g_idx_ext
			assign ci_ext = {{(IDXW-KW){1'b0}}, ci_new};
		end else begin : g_idx_full
			assign ci_ext = ci_new;
		end
	endgenerate

	assign upd_go   = !ent_q.last || !out_valid_q || pop;
	assign res_load = (state_q == ST_UPD) && upd_go && ent_q.last;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					ent_q <= q_entry;
					dvd_q <= {diff_abs, {FRAC{1'b0}}};
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
				dvd_q <= {dvd_q[NUMW-2:0], ge};
				cnt_q <= cnt_q + DIV_CW'(1);
			end
			ST_SAT: begin
				a_q <= a_sat;
			end
			ST_UPD: begin
				if (upd_go && ent_q.last) begin
					unique case (ent_q.op)
						OP_RELAXED: begin
							pass_done      <= 1'b0;
							step_length    <= r_new;
							bound_met      <= r_new < ONE_Q16;
							entering_index <= '0;
							entering_side  <= SIDE_LOWER;
							no_pivot_error <= 1'b0;
						end
						OP_FINAL: begin
							pass_done      <= 1'b1;
							step_length    <= c_new[DW-1] ? '0 : c_new;
							bound_met      <= 1'b0;
							entering_index <= ci_ext;
							entering_side  <= cs_new;
							no_pivot_error <= b_new <= {{(DW-TOLW){1'b0}}, ptol};
						end
						default: begin
							pass_done <= 1'b0;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			relaxed_q   <= ONE_Q16;
			best_q      <= '0;
			cstep_q     <= '0;
			cidx_q      <= '0;
			cside_q     <= SIDE_LOWER;
		end else begin
			priority if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_entry.div_en ? ST_DIV : ST_SAT;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
						unique case (ent_q.op)
							OP_RELAXED: begin
								relaxed_q <= r_new;
							end
							OP_FINAL: begin
								best_q  <= b_new;
								cstep_q <= c_new;
								cidx_q  <= ci_new;
								cside_q <= cs_new;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/bounded_two_pass_ratio_test_unit.sv =====
// A pass-one request with no crossed bound or a pass-two request on an unbounded side skips the
// divider and goes from idle through saturation and update; a divided ratio takes 49 divider steps.
// The back end takes no new request until it is through with the last one; a two-entry queue
// keeps accepting while the back end works or a result waits.
// Reset: arst_n clears all control, sets the pass-one step limit to 1.0, the pass-two
// selection to zero and the pivot tolerance to 1.
module bounded_two_pass_ratio_test_unit #(
	parameter int INDEX_WIDTH = btprt_pkg::INDEX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pivot_tolerance_we,
	input  logic [btprt_pkg::TOLW-1:0]   pivot_tolerance,
	input  logic                         push,
	output logic                         full,
	input  logic                         operation,
	input  logic                         first,
	input  logic                         last,
	input  logic signed [31:0]           direction,
	input  logic signed [31:0]           lower_bound,
	input  logic signed [31:0]           upper_bound,
	input  logic signed [31:0]           old_value,
	input  logic signed [31:0]           new_value,
	input  logic [btprt_pkg::IDXW-1:0]   element_index,
	output logic                         empty,
	input  logic                         pop,
	output logic                         pass_done,
	output logic signed [31:0]           step_length,
	output logic                         bound_met,
	output logic [btprt_pkg::IDXW-1:0]   entering_index,
	output logic                         entering_side,
	output logic                         no_pivot_error
);
	import btprt_pkg::*;

	`include "bounded_two_pass_ratio_test_unit_assert.svh"

	logic [TOLW-1:0] ptol_q;
	fe_entry_t       fe_entry;
	fe_entry_t       q_entry;
	logic            q_empty;
	logic            q_pop;
	logic            be_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptol_q <= PTOL_RESET;
		end else if (pivot_tolerance_we) begin
			ptol_q <= pivot_tolerance;
		end
	end

	btprt_front u_front (
		.operation     (operation),
		.first         (first),
		.last          (last),
		.direction     (direction),
		.lower_bound   (lower_bound),
		.upper_bound   (upper_bound),
		.old_value     (old_value),
		.new_value     (new_value),
		.element_index (element_index),
		.ptol          (ptol_q),
		.entry         (fe_entry)
	);

	btprt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (fe_entry),
		.full     (full),
		.pop      (q_pop),
		.rd_entry (q_entry),
		.empty    (q_empty)
	);

	btprt_back #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.ptol           (ptol_q),
		.q_entry        (q_entry),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.busy           (be_busy),
		.pop            (pop),
		.empty          (empty),
		.pass_done      (pass_done),
		.step_length    (step_length),
		.bound_met      (bound_met),
		.entering_index (entering_index),
		.entering_side  (entering_side),
		.no_pivot_error (no_pivot_error)
	);

	`BTPRT_ASSERT(a_idle_drains_full, clk, arst_n, ((full && !be_busy) |=> !full), "queue stuck full while back end idle")
	`BTPRT_ASSERT(a_pass1_fields, clk, arst_n, ((!empty && !pass_done) |-> ((entering_index == '0) && !no_pivot_error && !entering_side && (bound_met == (step_length < ONE_Q16)))), "pass-one result fields inconsistent")
	`BTPRT_ASSERT(a_pass2_clamp, clk, arst_n, ((!empty && pass_done) |-> (!step_length[31] && !bound_met)), "pass-two step not clamped")
	`BTPRT_ASSERT_ALWAYS(a_reset_clear, clk, (!arst_n |-> (empty && !full && !be_busy)), "control not cleared in reset")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for bounded_two_pass_ratio_test_unit: directed and random passes,
// checked field by field against an in-bench predictor of both ratio-test passes.
// Depends on btprt_pkg and the unit's RTL only.
module tb_top;
	import btprt_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int ITEMS_PER_PHASE = 193;

	typedef struct {
		op_t                op;
		logic               first;
		logic               last;
		logic signed [31:0] direction;
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic signed [31:0] old_value;
		logic signed [31:0] new_value;
		logic [IDXW-1:0]    element_index;
	} ratio_req_t;

	typedef struct {
		logic               pass_done;
		logic signed [31:0] step_length;
		logic               bound_met;
		logic [IDXW-1:0]    entering_index;
		logic               entering_side;
		logic               no_pivot_error;
	} ratio_result_t;

	class ratio_scoreboard;
		longint             tolerance;
		logic signed [31:0] relaxed_step;
		longint             best_pivot;
		logic signed [31:0] chosen_step;
		logic [IDXW-1:0]    chosen_index;
		logic               chosen_side;
		ratio_result_t      expected_q[$];
		int                 errors;

		function new();
			tolerance = PTOL_RESET;
			relaxed_step = ONE_Q16;
			best_pivot = 0;
			chosen_step = '0;
			chosen_index = '0;
			chosen_side = SIDE_LOWER;
			errors = 0;
		endfunction

		function void set_tolerance(logic [TOLW-1:0] v);
			tolerance = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// (bound - oldv) / den in Q16.16, truncated toward zero, saturated
		function logic signed [31:0] scaled_ratio(logic signed [31:0] bound,
				logic signed [31:0] oldv, logic signed [31:0] den);
			longint num;
			longint q;
			num = (longint'(bound) - longint'(oldv)) * 65536;
			q = num / longint'(den);
			if (q > longint'(S32_MAX))
				return S32_MAX;
			if (q < longint'(S32_MIN))
				return S32_MIN;
			return q[31:0];
		endfunction

		function void note_request(ratio_req_t r);
			longint             d;
			longint             mag;
			longint             tol10;
			logic signed [31:0] a;
			ratio_result_t      res;
			d = longint'(r.direction);
			mag = (d < 0) ? -d : d;
			if (r.op == OP_RELAXED) begin
				tol10 = 10 * tolerance;
				if (r.first)
					relaxed_step = ONE_Q16;
				if (d < -tol10 && r.lower_bound > r.new_value) begin
					a = scaled_ratio(r.lower_bound, r.old_value, r.direction);
					if (a < relaxed_step)
						relaxed_step = a;
				end else if (d > tol10 && r.upper_bound < r.new_value) begin
					a = scaled_ratio(r.upper_bound, r.old_value, r.direction);
					if (a < relaxed_step)
						relaxed_step = a;
				end
				if (r.last) begin
					res.pass_done = 1'b0;
					res.step_length = relaxed_step;
					res.bound_met = (relaxed_step < ONE_Q16);
					res.entering_index = '0;
					res.entering_side = 1'b0;
					res.no_pivot_error = 1'b0;
					expected_q.push_back(res);
				end
			end else begin
				if (r.first) begin
					best_pivot = 0;
					chosen_step = '0;
					chosen_index = '0;
					chosen_side = SIDE_LOWER;
				end
				if (mag > best_pivot) begin
					if (d < 0)
						a = (r.lower_bound == S32_MIN) ? S32_MAX :
							scaled_ratio(r.lower_bound, r.old_value, r.direction);
					else
						a = (r.upper_bound == S32_MAX) ? S32_MAX :
							scaled_ratio(r.upper_bound, r.old_value, r.direction);
					if (a < relaxed_step) begin
						best_pivot = mag;
						chosen_step = a;
						chosen_index = r.element_index;
						chosen_side = (d < 0) ? SIDE_LOWER : SIDE_UPPER;
					end
				end
				if (r.last) begin
					res.pass_done = 1'b1;
					res.step_length = (chosen_step < 0) ? 32'sd0 : chosen_step;
					res.bound_met = 1'b0;
					res.entering_index = chosen_index;
					res.entering_side = chosen_side;
					res.no_pivot_error = (best_pivot <= tolerance);
					expected_q.push_back(res);
				end
			end
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(ratio_result_t got);
			ratio_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: step %h index %h", $time,
					got.step_length, got.entering_index);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("pass_done", 32'(want.pass_done), 32'(got.pass_done));
			compare_field("step_length", want.step_length, got.step_length);
			compare_field("bound_met", 32'(want.bound_met), 32'(got.bound_met));
			compare_field("entering_index", 32'(want.entering_index),
				32'(got.entering_index));
			compare_field("entering_side", 32'(want.entering_side), 32'(got.entering_side));
			compare_field("no_pivot_error", 32'(want.no_pivot_error),
				32'(got.no_pivot_error));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               pivot_tolerance_we = 1'b0;
	logic [TOLW-1:0]    pivot_tolerance = '0;
	logic               push = 1'b0;
	logic               full;
	logic               operation = 1'b0;
	logic               first = 1'b0;
	logic               last = 1'b0;
	logic signed [31:0] direction = '0;
	logic signed [31:0] lower_bound = '0;
	logic signed [31:0] upper_bound = '0;
	logic signed [31:0] old_value = '0;
	logic signed [31:0] new_value = '0;
	logic [IDXW-1:0]    element_index = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic               pass_done;
	logic signed [31:0] step_length;
	logic               bound_met;
	logic [IDXW-1:0]    entering_index;
	logic               entering_side;
	logic               no_pivot_error;

	ratio_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	bounded_two_pass_ratio_test_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pivot_tolerance_we(pivot_tolerance_we),
		.pivot_tolerance(pivot_tolerance),
		.push(push),
		.full(full),
		.operation(operation),
		.first(first),
		.last(last),
		.direction(direction),
		.lower_bound(lower_bound),
		.upper_bound(upper_bound),
		.old_value(old_value),
		.new_value(new_value),
		.element_index(element_index),
		.empty(empty),
		.pop(pop),
		.pass_done(pass_done),
		.step_length(step_length),
		.bound_met(bound_met),
		.entering_index(entering_index),
		.entering_side(entering_side),
		.no_pivot_error(no_pivot_error)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no request moved for %0d cycles", $time, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		ratio_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got.pass_done = pass_done;
				got.step_length = step_length;
				got.bound_met = bound_met;
				got.entering_index = entering_index;
				got.entering_side = entering_side;
				got.no_pivot_error = no_pivot_error;
				sb.check_result(got);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send(input ratio_req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		operation <= r.op;
		first <= r.first;
		last <= r.last;
		direction <= r.direction;
		lower_bound <= r.lower_bound;
		upper_bound <= r.upper_bound;
		old_value <= r.old_value;
		new_value <= r.new_value;
		element_index <= r.element_index;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic wait_drained(input int extra);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOLW-1:0] v);
		pivot_tolerance_we <= 1'b1;
		pivot_tolerance <= v;
		@(posedge clk);
		pivot_tolerance_we <= 1'b0;
		sb.set_tolerance(v);
	endtask

	function automatic ratio_req_t make_element(op_t op, logic f, logic l,
			logic signed [31:0] dir, logic signed [31:0] lo, logic signed [31:0] hi,
			logic signed [31:0] oldv, logic signed [31:0] newv, logic [IDXW-1:0] idx);
		ratio_req_t r;
		r.op = op;
		r.first = f;
		r.last = l;
		r.direction = dir;
		r.lower_bound = lo;
		r.upper_bound = hi;
		r.old_value = oldv;
		r.new_value = newv;
		r.element_index = idx;
		return r;
	endfunction

	function automatic logic signed [31:0] random_q16();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return S32_MIN;
					1: return S32_MAX;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			1, 2: return $urandom;
			default: return int'($urandom_range(1 << 21)) - (1 << 20);
		endcase
	endfunction

	function automatic ratio_req_t random_element(op_t op, logic f, logic l);
		ratio_req_t r;
		int t;
		r.op = op;
		r.first = f;
		r.last = l;
		r.old_value = random_q16();
		r.lower_bound = r.old_value - $urandom_range(1 << 19);
		r.upper_bound = r.old_value + $urandom_range(1 << 19);
		if ($urandom_range(9) == 0)
			r.lower_bound = S32_MIN;
		if ($urandom_range(9) == 0)
			r.upper_bound = S32_MAX;
		if ($urandom_range(19) == 0) begin
			r.lower_bound = $urandom;
			r.upper_bound = $urandom;
		end
		r.new_value = r.old_value + (int'($urandom_range(1 << 21)) - (1 << 20));
		if ($urandom_range(19) == 0)
			r.new_value = $urandom;
		case ($urandom_range(19))
			0: r.direction = S32_MIN;
			1: r.direction = S32_MAX;
			2: r.direction = 32'sd0;
			3, 4, 5: begin
				// right around the pass-one or pass-two threshold
				t = int'(sb.tolerance) * ($urandom_range(1) ? 10 : 1) + int'($urandom_range(2)) - 1;
				r.direction = $urandom_range(1) ? t : -t;
			end
			6, 7, 8: r.direction = $urandom;
			default: r.direction = int'($urandom_range(1 << 20)) - (1 << 19);
		endcase
		r.element_index = 16'($urandom_range(16'hFFFF));
		return r;
	endfunction

	task automatic run_random(input int count);
		int sent;
		int n;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 85) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					send(random_element(OP_RELAXED, i == 0, i == n - 1));
				sent += n;
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send(random_element(OP_FINAL, i == 0, i == n - 1));
				sent += n;
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send(random_element(op_t'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1))));
				sent += n;
			end
		end
	endtask

	initial begin
		logic [TOLW-1:0] tol_plan[8];
		sb = new();
		tol_plan = '{16'd0, 16'hFFFF, 16'd1, 16'(3 + $urandom_range(40)),
			16'($urandom_range(16'hFFFF)), 16'd7, 16'hFFFF, 16'd0};
		#1;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset tolerance of 1: pass one threshold is 10
		send(make_element(OP_FINAL, 1, 1, -(2 << 16), S32_MIN, 0, 0, 0, 16'h0001));
		send(make_element(OP_FINAL, 1, 1, 2 << 16, S32_MIN, 1 << 16, 0, 0, 16'hFFFF));
		send(make_element(OP_RELAXED, 1, 1, 0, 0, 0, 0, 0, 16'h0000));
		send(make_element(OP_RELAXED, 1, 0, -(3 << 16), 0, S32_MAX, 1 << 16, -(1 << 16), 2));
		send(make_element(OP_RELAXED, 0, 0, 10, S32_MIN, 0, 0, 5 << 16, 3));
		send(make_element(OP_RELAXED, 0, 1, 4 << 16, S32_MIN, 2 << 16, 0, 5 << 16, 4));
		send(make_element(OP_FINAL, 1, 0, -1, 1 << 20, S32_MAX, 0, 0, 5));
		send(make_element(OP_FINAL, 0, 0, S32_MIN, 0, S32_MAX, S32_MAX, 0, 6));
		send(make_element(OP_FINAL, 0, 1, 3 << 16, S32_MIN, S32_MAX, 0, 0, 7));
		send(make_element(OP_RELAXED, 1, 1, 11, S32_MIN, S32_MIN, S32_MAX, 0, 8));
		send(make_element(OP_FINAL, 1, 1, S32_MAX, S32_MIN, 0, S32_MIN, 0, 9));
		send(make_element(OP_RELAXED, 1, 0, -11, S32_MAX, S32_MAX, S32_MIN, 0, 10));
		send(make_element(OP_RELAXED, 0, 1, -10, S32_MAX, S32_MAX, S32_MIN, 0, 10));
		send(make_element(OP_RELAXED, 1, 1, 1 << 16, S32_MIN, 3 << 16, 0, 4 << 16, 11));
		send(make_element(OP_FINAL, 0, 0, -(1 << 16), -(1 << 15), S32_MAX, 0, 0, 12));
		send(make_element(OP_FINAL, 0, 1, -(2 << 16), -(1 << 16), S32_MAX, 0, 0, 13));
		send(make_element(OP_FINAL, 0, 1, 1, S32_MIN, S32_MAX, 0, 0, 16'h8000));
		wait_drained(DRAIN_CYCLES);

		for (int phase = 0; phase < 8; phase++) begin
			write_tolerance(tol_plan[phase]);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			// fill the unit and back up the request side
			if (phase == 4)
				hold_cycles = 400;
			run_random(ITEMS_PER_PHASE);
			wait_drained(DRAIN_CYCLES);
		end

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
